// ===== hdl/cpvd_pkg.sv =====
// Shared types and constants for the complex polynomial value and derivatives unit.
package cpvd_pkg;

  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 24;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_REAL = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POINT_IMAG = 1'd1;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] re;
    logic signed [WORD_BITS-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] coef_real;
    logic signed [WORD_BITS-1:0] coef_imag;
    logic                        last_coef;
  } cpvd_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] value_real;
    logic signed [WORD_BITS-1:0] value_imag;
    logic signed [WORD_BITS-1:0] slope_real;
    logic signed [WORD_BITS-1:0] slope_imag;
    logic signed [WORD_BITS-1:0] curve_real;
    logic signed [WORD_BITS-1:0] curve_imag;
  } cpvd_out_t;

endpackage

// ===== hdl/cpvd_cmac.sv =====
// One complex multiply-add a*x + c with floored products and saturated parts.
module cpvd_cmac import cpvd_pkg::*; #(
  parameter int FRAC = FRAC_BITS
) (
  input  cplx_t acc,
  input  cplx_t point,
  input  cplx_t addend,
  output cplx_t result
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW - FRAC + 2;

  localparam word_t SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [SW-1:0] f_rr, f_ii, f_ri, f_ir;
  logic signed [SW-1:0] sum_re, sum_im;
  logic                 ovf_re, ovf_im;

  // Full-precision products, then floor by an arithmetic shift
  assign p_rr = acc.re * point.re;
  assign p_ii = acc.im * point.im;
  assign p_ri = acc.re * point.im;
  assign p_ir = acc.im * point.re;

  assign f_rr = SW'(p_rr >>> FRAC);
  assign f_ii = SW'(p_ii >>> FRAC);
  assign f_ri = SW'(p_ri >>> FRAC);
  assign f_ir = SW'(p_ir >>> FRAC);

  assign sum_re = f_rr - f_ii + SW'(addend.re);
  assign sum_im = f_ri + f_ir + SW'(addend.im);

  // Out of range when the bits above the word are not all copies of its sign
  assign ovf_re = (sum_re[SW-1:WORD_BITS-1] != {(SW-WORD_BITS+1){sum_re[SW-1]}});
  assign ovf_im = (sum_im[SW-1:WORD_BITS-1] != {(SW-WORD_BITS+1){sum_im[SW-1]}});

  assign result.re = ovf_re ? (sum_re[SW-1] ? SAT_MIN : SAT_MAX) : sum_re[WORD_BITS-1:0];
  assign result.im = ovf_im ? (sum_im[SW-1] ? SAT_MIN : SAT_MAX) : sum_im[WORD_BITS-1:0];

endmodule

// ===== hdl/complex_poly_value_and_derivatives_unit.sv =====
// Top level: streaming Horner evaluation of a complex polynomial and its two derivatives.
//
// Feed the complex coefficients of a polynomial, highest degree first, one per
// input beat; mark the constant term with last_coef. The unit evaluates p(x),
// p'(x) and p''(x) at the point held in the two configuration registers (signed
// fixed point, FRAC_BITS fractional bits, Q8.24 by default) and emits one
// result beat per polynomial, then starts clean on the next one. Every product
// is rounded toward minus infinity and every result part saturates. Throughput
// is one coefficient per clock cycle with no gaps between polynomials, unless a
// last coefficient waits on a stalled, full result register: the recurrence runs
// through twelve parallel word-by-word multipliers feeding the accumulator
// registers, and that combinational loop sets the rate. The beat carrying the
// last coefficient passes the input register, then the result register, before
// the result beat is offered. The input register keeps accepting while a
// finished result waits; only a last coefficient held behind a stalled, full
// result register blocks the input. Write the point only while the unit is idle.
module complex_poly_value_and_derivatives_unit import cpvd_pkg::*; #(
  parameter int FRAC_BITS_P = FRAC_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [WORD_BITS-1:0]    cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  cpvd_in_t                in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output cpvd_out_t               out_data
);

  localparam word_t SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Evaluation point
  cplx_t     point_r;

  // Input register
  logic      s1_valid_r;
  cpvd_in_t  s1_data_r;

  // Horner accumulators
  cplx_t     val_r, slp_r, crv_r;
  cplx_t     val_nxt, slp_nxt, crv_nxt;
  cplx_t     coef;

  // Result register
  logic      out_valid_r;
  cpvd_out_t out_data_r;

  logic      out_free;
  logic      s1_go;
  logic      in_take;
  word_t     crv2_re, crv2_im;

  // Advance the input register unless a last coefficient has nowhere to land
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (!s1_data_r.last_coef || out_free);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  assign coef.re = s1_data_r.coef_real;
  assign coef.im = s1_data_r.coef_imag;

  // All three updates read the old accumulators
  cpvd_cmac #(.FRAC(FRAC_BITS_P)) u_cmac_crv (
    .acc    (crv_r),
    .point  (point_r),
    .addend (slp_r),
    .result (crv_nxt)
  );

  cpvd_cmac #(.FRAC(FRAC_BITS_P)) u_cmac_slp (
    .acc    (slp_r),
    .point  (point_r),
    .addend (val_r),
    .result (slp_nxt)
  );

  cpvd_cmac #(.FRAC(FRAC_BITS_P)) u_cmac_val (
    .acc    (val_r),
    .point  (point_r),
    .addend (coef),
    .result (val_nxt)
  );

  // Second derivative is twice the curve accumulator; overflow when the top
  // two bits differ
  assign crv2_re = (crv_nxt.re[WORD_BITS-1] != crv_nxt.re[WORD_BITS-2]) ?
                   (crv_nxt.re[WORD_BITS-1] ? SAT_MIN : SAT_MAX) :
                   {crv_nxt.re[WORD_BITS-2:0], 1'b0};
  assign crv2_im = (crv_nxt.im[WORD_BITS-1] != crv_nxt.im[WORD_BITS-2]) ?
                   (crv_nxt.im[WORD_BITS-1] ? SAT_MIN : SAT_MAX) :
                   {crv_nxt.im[WORD_BITS-2:0], 1'b0};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_REAL: point_r.re <= cfg_data;
        CFG_POINT_IMAG: point_r.im <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data_r <= in_data;
    end
  end

  // Accumulators: update per coefficient, clear after the constant term
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      slp_r <= '0;
      crv_r <= '0;
    end else if (s1_go) begin
      if (s1_data_r.last_coef) begin
        val_r <= '0;
        slp_r <= '0;
        crv_r <= '0;
      end else begin
        val_r <= val_nxt;
        slp_r <= slp_nxt;
        crv_r <= crv_nxt;
      end
    end
  end

  // Result register: load on the constant term, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_data_r.last_coef) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_data_r.last_coef) begin
      out_data_r.value_real <= val_nxt.re;
      out_data_r.value_imag <= val_nxt.im;
      out_data_r.slope_real <= slp_nxt.re;
      out_data_r.slope_imag <= slp_nxt.im;
      out_data_r.curve_real <= crv2_re;
      out_data_r.curve_imag <= crv2_im;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/complex_poly_value_and_derivatives_unit_test.sv =====
// Self-checking bench for the complex Horner value/slope/curve evaluation unit.
module complex_poly_value_and_derivatives_unit_test import cpvd_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Q8.24 landmarks used by the directed tests
  localparam word_t ONE       = 32'sh0100_0000;
  localparam word_t HALF      = 32'sh0080_0000;
  localparam word_t WORD_MAX  = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN  = 32'sh8000_0000;
  localparam longint SAT_HI   = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint SAT_LO   = -(longint'(1) <<< (WORD_BITS - 1));
  // cycles to let a coefficient with no result drain through the two register stages
  localparam int IDLE_SETTLE  = 8;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [WORD_BITS-1:0]    cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  cpvd_in_t                in_data;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  cpvd_out_t               out_data;

  // Evaluation point and the three Horner accumulators, mirrored in the bench
  cplx_t point     = '0;
  cplx_t value_acc = '0;
  cplx_t slope_acc = '0;
  cplx_t curve_acc = '0;

  // Results owed by the unit, oldest first
  cpvd_out_t pending_evals[$];

  int errors = 0;

  // Pacing knobs: quiet turns idling off on that side, hold_len asks the
  // receiver for one long hold-off of that many cycles
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  int hold_len = 0;
  int rx_stall_left = 0;
  int rx_free_left = 0;

  complex_poly_value_and_derivatives_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the unit
  // ---------------------------------------------------------------------------

  // Exact product, then round toward minus infinity by the fraction width
  function automatic longint floor_mul(word_t a, word_t b);
    return (longint'(a) * longint'(b)) >>> FRAC_BITS;
  endfunction

  function automatic word_t clamp(longint v);
    if (v > SAT_HI) return WORD_MAX;
    if (v < SAT_LO) return WORD_MIN;
    return word_t'(v);
  endfunction

  // acc * point + addend, each part summed exactly and then saturated
  function automatic cplx_t mul_add(cplx_t acc, cplx_t addend);
    cplx_t r;
    r.re = clamp(floor_mul(acc.re, point.re) - floor_mul(acc.im, point.im)
                 + longint'(addend.re));
    r.im = clamp(floor_mul(acc.re, point.im) + floor_mul(acc.im, point.re)
                 + longint'(addend.im));
    return r;
  endfunction

  // Advance all three accumulators from their old values; on the constant
  // term queue p, p' and the doubled curve accumulator, then start clean
  task automatic horner_step(cpvd_in_t beat);
    cplx_t coef;
    cplx_t next_curve;
    cplx_t next_slope;
    cpvd_out_t res;
    coef.re = beat.coef_real;
    coef.im = beat.coef_imag;
    next_curve = mul_add(curve_acc, slope_acc);
    next_slope = mul_add(slope_acc, value_acc);
    value_acc  = mul_add(value_acc, coef);
    curve_acc  = next_curve;
    slope_acc  = next_slope;
    if (beat.last_coef) begin
      res.value_real = value_acc.re;
      res.value_imag = value_acc.im;
      res.slope_real = slope_acc.re;
      res.slope_imag = slope_acc.im;
      res.curve_real = clamp(2 * longint'(curve_acc.re));
      res.curve_imag = clamp(2 * longint'(curve_acc.im));
      pending_evals.push_back(res);
      value_acc = '0;
      slope_acc = '0;
      curve_acc = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Random sources
  // ---------------------------------------------------------------------------

  // Mostly short gaps, now and then a long one
  function automatic int tx_gap();
    int roll;
    if (tx_quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // A quarter full-range words (every bit toggles), the rest small, within +/-4.0
  function automatic word_t rand_coef();
    if ($urandom_range(0, 3) == 0) return word_t'($urandom);
    return word_t'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
  endfunction

  function automatic word_t rand_point(int span);
    return word_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic int poly_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, 8);
    return $urandom_range(9, 16);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one coefficient beat, hold it until accepted, then idle a while.
  // Valid stays high when no gap follows, so back-to-back beats never drop it.
  task automatic send_coef(word_t re, word_t im, bit last);
    cpvd_in_t beat;
    int gap;
    beat.coef_real = re;
    beat.coef_imag = im;
    beat.last_coef = last;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    horner_step(beat);
    gap = tx_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_poly(int len);
    for (int k = 0; k < len; k++)
      send_coef(rand_coef(), rand_coef(), k == len - 1);
  endtask

  // Drop valid, wait for every owed result, then let any trailing
  // coefficient without a result work through the pipeline
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_evals.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Write both point registers while the unit is idle; end on a rising edge
  // so pacing knobs changed afterward never meet the falling-edge processes
  task automatic write_point(word_t re, word_t im);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POINT_REAL;
    cfg_data  <= re;
    @(negedge clk);
    cfg_index <= CFG_POINT_IMAG;
    cfg_data  <= im;
    @(negedge clk);
    cfg_we <= 1'b0;
    point.re = re;
    point.im = im;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver pacing: a requested hold-off wins, otherwise pick random stretches
  always @(negedge clk) begin : rx_pacing
    int roll;
    if (hold_len > 0) begin
      rx_stall_left = hold_len;
      rx_free_left  = 0;
      hold_len      = 0;
    end
    if (rx_stall_left == 0 && rx_free_left == 0 && !rx_quiet) begin
      roll = $urandom_range(0, 99);
      if (roll < 25)
        rx_stall_left = $urandom_range(1, 3);
      else if (roll < 30)
        rx_stall_left = $urandom_range(10, 40);
      else
        rx_free_left = $urandom_range(1, 8);
    end
    if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rx_free_left > 0) rx_free_left--;
    end
  end

  task automatic check_field(string name, word_t want, word_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Compare each accepted result beat with the oldest owed result
  always @(posedge clk) begin : result_check
    cpvd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_evals.size() == 0) begin
        $error("result beat with no polynomial pending");
        errors++;
      end else begin
        want = pending_evals.pop_front();
        check_field("value_real", want.value_real, out_data.value_real);
        check_field("value_imag", want.value_imag, out_data.value_imag);
        check_field("slope_real", want.slope_real, out_data.slope_real);
        check_field("slope_imag", want.slope_imag, out_data.slope_imag);
        check_field("curve_real", want.curve_real, out_data.curve_real);
        check_field("curve_imag", want.curve_imag, out_data.curve_imag);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Point is zero out of reset: a polynomial collapses to its constant term,
  // a single coefficient gives zero derivatives
  task automatic test_reset_point();
    send_coef(WORD_MAX, WORD_MIN, 1'b1);
    send_coef(WORD_MIN, WORD_MAX, 1'b1);
    send_coef(WORD_MAX, WORD_MAX, 1'b0);
    send_coef(word_t'(1), word_t'(-1), 1'b1);
  endtask

  task automatic test_corner_points();
    // real unit point: p = 1 + 2 + (3 + 0.5i)
    write_point(ONE, '0);
    send_coef(ONE, '0, 1'b0);
    send_coef(word_t'(2 * ONE), '0, 1'b0);
    send_coef(word_t'(3 * ONE), HALF, 1'b1);
    // imaginary unit point exercises the cross terms
    write_point('0, ONE);
    send_coef('0, ONE, 1'b0);
    send_coef(word_t'(-ONE), '0, 1'b0);
    send_coef(HALF, word_t'(-HALF), 1'b1);
    // extreme point and coefficients: every result part ends at a word limit
    write_point(WORD_MAX, WORD_MIN);
    send_coef(WORD_MAX, WORD_MIN, 1'b0);
    send_coef(WORD_MIN, WORD_MAX, 1'b0);
    send_coef(WORD_MAX, WORD_MAX, 1'b0);
    send_coef(WORD_MIN, WORD_MIN, 1'b1);
    // one negative LSB: tiny products must round down to -1, not to zero
    write_point(word_t'(-1), word_t'(-1));
    send_coef(word_t'(1), word_t'(1), 1'b0);
    send_coef(word_t'(-1), '0, 1'b0);
    send_coef('0, '0, 1'b1);
    // long run before the constant term: accumulators grow into saturation
    write_point(word_t'(2 * ONE), '0);
    repeat (6) send_coef(WORD_MAX, WORD_MAX, 1'b0);
    send_coef('0, '0, 1'b1);
  endtask

  task automatic test_random_polys();
    int sent;
    int len;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_point(rand_point(3 << 23), rand_point(3 << 23));
        1:       write_point(word_t'($urandom), word_t'($urandom));
        2:       write_point(rand_point(1 << 22), rand_point(1 << 22));
        default: write_point(rand_point(1 << 24), rand_point(1 << 24));
      endcase
      // one phase runs with no idling on either side
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 2);
      sent = 0;
      while (sent < 68) begin
        len = poly_len();
        send_poly(len);
        sent += len;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    write_point(rand_point(1 << 24), rand_point(1 << 24));
    // hold the receiver off while short polynomials stream in at full rate,
    // so the result register fills and the input stalls
    hold_len = 300;
    tx_quiet = 1'b1;
    repeat (40) send_poly($urandom_range(1, 2));
    tx_quiet = 1'b0;
    wait_idle();
    repeat (6) send_poly(poly_len());
    // pause the sender until every owed result is out
    wait_idle();
    repeat (6) send_poly(poly_len());
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_point();
    test_corner_points();
    test_random_polys();
    test_backpressure();

    wait_idle();
    if (errors == 0) begin
      $display("PASS complex_poly_value_and_derivatives_unit");
    end else begin
      $display("FAIL complex_poly_value_and_derivatives_unit");
    end
    $finish;
  end

  // Far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("FAIL complex_poly_value_and_derivatives_unit");
    $finish;
  end

endmodule

// ===== complex_poly_value_and_derivatives_unit.f =====
hdl/cpvd_pkg.sv
hdl/cpvd_cmac.sv
hdl/complex_poly_value_and_derivatives_unit.sv
bench/complex_poly_value_and_derivatives_unit_test.sv
